// ===== hw/rtl/dt_pkg.sv =====
// Shared constants, command and status types for the decimal truncate block.
package dt_pkg;

  localparam int MANTISSA_BITS_DEF = 96;
  localparam int CHUNK_BITS        = 16;
  localparam int REM_BITS          = 4;
  localparam int NUM_BITS          = CHUNK_BITS + REM_BITS;
  localparam int RECIP_SHIFT       = 23;
  localparam logic [NUM_BITS-1:0] RECIP_TEN = NUM_BITS'(838861);
  localparam logic [1:0] KIND_NORMAL = 2'd0;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic step;
    logic emit;
  } dt_cmd_t;

  typedef struct packed {
    logic mant_zero;
    logic chunk_last;
    logic scale_done;
  } dt_sts_t;

endpackage

// ===== hw/rtl/dt_ifs.sv =====
// Valid/ready channel interfaces for the input and result beats.
interface dt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] mantissa_low;
  logic [31:0] mantissa_high;
  logic        negative;
  logic [7:0]  scale;
  logic [1:0]  value_kind;

  modport source (output valid, mantissa_low, mantissa_high, negative, scale, value_kind,
                  input ready);
  modport sink (input valid, mantissa_low, mantissa_high, negative, scale, value_kind,
                output ready);
endinterface

interface dt_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [31:0] result_high;
  logic        result_negative;
  logic [7:0]  result_scale;
  logic [1:0]  result_kind;

  modport source (output valid, result_low, result_high, result_negative, result_scale,
                  result_kind, input ready);
  modport sink (input valid, result_low, result_high, result_negative, result_scale,
                result_kind, output ready);
endinterface

// ===== hw/rtl/decimal_truncate_top.sv =====
// Top level of the decimal truncate block: controller, datapath and checks.
// Each input beat carries a decimal value; the result beat holds the mantissa divided by ten
// once per unit of scale with remainders dropped, scale zero and the sign kept, or all zero
// with the kind passed on for a non-normal kind. One divide by ten runs through a shared
// 16-bit chunk divider, one chunk per cycle; a pass is a check state and then one step per
// chunk. An item makes k passes, where k is the scale, cut short once the mantissa reaches
// zero; one item is in work at a time, and a new beat is taken while a result waits.
module decimal_truncate_top #(
  parameter int MANTISSA_BITS = dt_pkg::MANTISSA_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  dt_in_if.sink    in_ch,
  dt_out_if.source out_ch
);
  import dt_pkg::*;

  dt_cmd_t cmd;
  dt_sts_t sts;

  dt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dt_datapath #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_datapath (
    .clk                 (clk),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mantissa_low     (in_ch.mantissa_low),
    .in_mantissa_high    (in_ch.mantissa_high),
    .in_negative         (in_ch.negative),
    .in_scale            (in_ch.scale),
    .in_value_kind       (in_ch.value_kind),
    .out_result_low      (out_ch.result_low),
    .out_result_high     (out_ch.result_high),
    .out_result_negative (out_ch.result_negative),
    .out_result_scale    (out_ch.result_scale),
    .out_result_kind     (out_ch.result_kind)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("Input beat taken while an item was still in work.");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_ch.valid || out_ch.ready)
    else $error("Result register loaded over a beat not yet taken.");

  a_emit_leaves_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("Result register loaded without presenting a beat.");

  a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.result_kind != KIND_NORMAL) |->
      (out_ch.result_low == 64'd0) && (out_ch.result_high == 32'd0) &&
      !out_ch.result_negative)
    else $error("Non-normal value left a nonzero mantissa or sign.");
`endif

endmodule

// ===== hw/rtl/dt_datapath.sv =====
// Datapath: mantissa register, chunked divide-by-ten unit, counters and result register.
module dt_datapath #(
  parameter int MANTISSA_BITS = dt_pkg::MANTISSA_BITS_DEF
) (
  input  logic            clk,
  input  dt_pkg::dt_cmd_t cmd,
  output dt_pkg::dt_sts_t sts,
  input  logic [63:0]     in_mantissa_low,
  input  logic [31:0]     in_mantissa_high,
  input  logic            in_negative,
  input  logic [7:0]      in_scale,
  input  logic [1:0]      in_value_kind,
  output logic [63:0]     out_result_low,
  output logic [31:0]     out_result_high,
  output logic            out_result_negative,
  output logic [7:0]      out_result_scale,
  output logic [1:0]      out_result_kind
);
  import dt_pkg::*;

  localparam int CHUNKS = (MANTISSA_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD    = CHUNKS * CHUNK_BITS;
  localparam int EXT    = (PAD > 96) ? PAD : 96;
  localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [PAD-1:0]      work_r;
  logic [REM_BITS-1:0] rem_r;
  logic [CNT_W-1:0]    chunk_cnt_r;
  logic [7:0]          scale_cnt_r;
  logic                neg_r;
  logic [1:0]          kind_r;

  logic [EXT-1:0]        in_ext;
  logic [EXT-1:0]        in_mask;
  logic [EXT-1:0]        work_ext;
  logic [NUM_BITS-1:0]   num;
  logic [2*NUM_BITS-1:0] prod;
  logic [CHUNK_BITS-1:0] quo;
  logic [NUM_BITS-1:0]   quo_ten;
  logic [NUM_BITS-1:0]   rem_full;
  logic                  is_normal;

  assign is_normal = (in_value_kind == KIND_NORMAL);
  assign in_ext    = EXT'({in_mantissa_high, in_mantissa_low});
  assign in_mask   = EXT'({MANTISSA_BITS{1'b1}});
  assign work_ext  = EXT'(work_r);

  // One chunk of long division: the remainder so far above the next chunk, divided by
  // ten through a reciprocal multiply that is exact for every value this can take.
  assign num      = {rem_r, work_r[PAD-1 -: CHUNK_BITS]};
  assign prod     = (2*NUM_BITS)'(num) * (2*NUM_BITS)'(RECIP_TEN);
  assign quo      = prod[RECIP_SHIFT +: CHUNK_BITS];
  assign quo_ten  = NUM_BITS'({quo, 3'b000}) + NUM_BITS'({quo, 1'b0});
  assign rem_full = num - quo_ten;

  assign sts.mant_zero  = ~|work_r;
  assign sts.chunk_last = (chunk_cnt_r == CNT_W'(CHUNKS - 1));
  assign sts.scale_done = (scale_cnt_r == 8'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r      <= is_normal ? PAD'(in_ext & in_mask) : '0;
      neg_r       <= is_normal & in_negative;
      scale_cnt_r <= is_normal ? in_scale : 8'd0;
      kind_r      <= in_value_kind;
    end
    if (cmd.pass_start) begin
      rem_r       <= '0;
      chunk_cnt_r <= '0;
    end
    if (cmd.step) begin
      work_r      <= {work_r[PAD-CHUNK_BITS-1:0], quo};
      rem_r       <= rem_full[REM_BITS-1:0];
      chunk_cnt_r <= chunk_cnt_r + CNT_W'(1);
      if (sts.chunk_last) begin
        scale_cnt_r <= scale_cnt_r - 8'd1;
      end
    end
    if (cmd.emit) begin
      out_result_low      <= work_ext[63:0];
      out_result_high     <= work_ext[95:64];
      out_result_negative <= neg_r;
      out_result_kind     <= kind_r;
    end
  end

  assign out_result_scale = 8'd0;

endmodule

// ===== hw/rtl/dt_ctrl.sv =====
// Controller: sequences load, division passes and the result beat.
module dt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  dt_pkg::dt_sts_t sts,
  output dt_pkg::dt_cmd_t cmd
);
  import dt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;
  logic   div_done;

  assign slot_free = !out_valid_r || out_ready;
  assign div_done  = sts.scale_done || sts.mant_zero;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load       = (state_r == ST_IDLE) && in_valid;
  assign cmd.pass_start = (state_r == ST_CHECK) && !div_done;
  assign cmd.step       = (state_r == ST_DIV);
  assign cmd.emit       = (state_r == ST_FIN) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !cmd.emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_r <= div_done ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          if (sts.chunk_last) begin
            state_r <= ST_CHECK;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/tb_decimal_truncate_top.sv =====
// Self-checking testbench for decimal_truncate_top: directed and random beats with a scoreboard.
`timescale 1ns / 100ps

module tb_decimal_truncate_top;
  import dt_pkg::*;

  localparam logic [1:0] KIND_INF     = 2'd1;
  localparam logic [1:0] KIND_NEG_INF = 2'd2;
  localparam logic [1:0] KIND_NAN     = 2'd3;
  localparam int         MANT_W       = MANTISSA_BITS_DEF;
  localparam int         N_RANDOM     = 1600;
  localparam int         DRAIN_CYCLES = 300;
  localparam int         HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [63:0] mantissa_low;
    logic [31:0] mantissa_high;
    logic        negative;
    logic [7:0]  scale;
    logic [1:0]  value_kind;
  } dec_in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [31:0] result_high;
    logic        result_negative;
    logic [7:0]  result_scale;
    logic [1:0]  result_kind;
  } dec_out_t;

  class truncate_scoreboard;
    dec_out_t pending[$];
    int       failures = 0;

    function automatic dec_out_t truncate_value(dec_in_t v);
      logic [127:0] mant;
      dec_out_t     r;
      mant = {32'd0, v.mantissa_high, v.mantissa_low} & ((128'd1 << MANT_W) - 128'd1);
      r.result_negative = v.negative;
      if (v.value_kind == KIND_NORMAL) begin
        for (int n = 0; n < v.scale; n++) begin
          if (mant == '0) break;
          mant = mant / 128'd10;
        end
      end else begin
        mant = '0;
        r.result_negative = 1'b0;
      end
      r.result_low   = mant[63:0];
      r.result_high  = mant[95:64];
      r.result_scale = 8'd0;
      r.result_kind  = v.value_kind;
      return r;
    endfunction

    function void note_input(dec_in_t v);
      pending.push_back(truncate_value(v));
    endfunction

    function void check_result(dec_out_t r);
      dec_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: %h", r);
        failures++;
        return;
      end
      e = pending.pop_front();
      if (r.result_low !== e.result_low) begin
        $error("result_low: expected %h, actual %h", e.result_low, r.result_low);
        failures++;
      end
      if (r.result_high !== e.result_high) begin
        $error("result_high: expected %h, actual %h", e.result_high, r.result_high);
        failures++;
      end
      if (r.result_negative !== e.result_negative) begin
        $error("result_negative: expected %b, actual %b", e.result_negative,
               r.result_negative);
        failures++;
      end
      if (r.result_scale !== e.result_scale) begin
        $error("result_scale: expected %h, actual %h", e.result_scale, r.result_scale);
        failures++;
      end
      if (r.result_kind !== e.result_kind) begin
        $error("result_kind: expected %h, actual %h", e.result_kind, r.result_kind);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dt_in_if  in_if ();
  dt_out_if out_if ();

  decimal_truncate_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  truncate_scoreboard sb;
  bit send_gaps = 1'b1;
  bit take_gaps = 1'b1;
  int n_results = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic dec_in_t make_value(logic [95:0] mant, logic neg, logic [7:0] scale,
                                         logic [1:0] kind);
    dec_in_t v;
    v.mantissa_low  = mant[63:0];
    v.mantissa_high = mant[95:64];
    v.negative      = neg;
    v.scale         = scale;
    v.value_kind    = kind;
    return v;
  endfunction

  function automatic dec_in_t random_value();
    logic [95:0] mant;
    logic [7:0]  scale;
    logic [1:0]  kind;
    int unsigned sel;
    mant = {$urandom(), $urandom(), $urandom()};
    case ($urandom_range(0, 3))
      1: mant = mant >> $urandom_range(1, 95);
      2: mant = 96'($urandom_range(0, 100000));
      default: ;
    endcase
    sel = $urandom_range(0, 9);
    if (sel < 7) scale = 8'($urandom_range(0, 30));
    else if (sel < 9) scale = 8'($urandom_range(0, 3));
    else scale = 8'($urandom_range(0, 255));
    kind = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : KIND_NORMAL;
    return make_value(mant, 1'($urandom_range(0, 1)), scale, kind);
  endfunction

  task automatic send_value(dec_in_t v);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid         = 1'b1;
    in_if.mantissa_low  = v.mantissa_low;
    in_if.mantissa_high = v.mantissa_high;
    in_if.negative      = v.negative;
    in_if.scale         = v.scale;
    in_if.value_kind    = v.value_kind;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(v);
  endtask

  // Result side: random stalls, and two long hold-offs so that the input backs up.
  initial begin
    int unsigned gap;
    dec_out_t    r;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (n_results == 150 || n_results == 900) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_if.ready = 1'b0;
        end
      end
      if (n_results % 100 == 0) take_gaps = ($urandom_range(0, 2) != 0);
      gap = take_gaps ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_if.ready = 1'b0;
      end
      @(negedge clk);
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      r.result_low      = out_if.result_low;
      r.result_high     = out_if.result_high;
      r.result_negative = out_if.result_negative;
      r.result_scale    = out_if.result_scale;
      r.result_kind     = out_if.result_kind;
      sb.check_result(r);
      n_results++;
    end
  end

  initial begin
    logic [95:0] all_ones;
    sb = new;
    all_ones = '1;
    in_if.valid         = 1'b0;
    in_if.mantissa_low  = '0;
    in_if.mantissa_high = '0;
    in_if.negative      = 1'b0;
    in_if.scale         = '0;
    in_if.value_kind    = KIND_NORMAL;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_value(make_value('0, 1'b0, 8'd0, KIND_NORMAL));
    send_value(make_value(all_ones, 1'b0, 8'd0, KIND_NORMAL));
    send_value(make_value(all_ones, 1'b1, 8'd1, KIND_NORMAL));
    send_value(make_value(all_ones, 1'b0, 8'd28, KIND_NORMAL));
    send_value(make_value(all_ones, 1'b0, 8'd29, KIND_NORMAL));
    send_value(make_value(all_ones, 1'b1, 8'd255, KIND_NORMAL));
    send_value(make_value('0, 1'b1, 8'd255, KIND_NORMAL));
    send_value(make_value(96'd1000, 1'b0, 8'd3, KIND_NORMAL));
    send_value(make_value(96'd999, 1'b1, 8'd3, KIND_NORMAL));
    send_value(make_value(96'd9, 1'b1, 8'd128, KIND_NORMAL));
    send_value(make_value({32'd1, 64'd0}, 1'b0, 8'd1, KIND_NORMAL));
    send_value(make_value({32'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, 8'd20, KIND_NORMAL));
    send_value(make_value({32'hFFFF_FFFF, 64'd0}, 1'b1, 8'd10, KIND_NORMAL));
    send_value(make_value(all_ones, 1'b1, 8'd255, KIND_INF));
    send_value(make_value(all_ones, 1'b1, 8'd5, KIND_NEG_INF));
    send_value(make_value(all_ones, 1'b1, 8'd0, KIND_NAN));
    send_value(make_value('0, 1'b0, 8'd0, KIND_INF));
    send_value(make_value(96'd12345, 1'b1, 8'd255, KIND_NAN));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) send_gaps = ($urandom_range(0, 2) != 0);
      send_value(random_value());
    end
    @(negedge clk);
    in_if.valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dt_pkg.sv
hw/rtl/dt_ifs.sv
hw/rtl/dt_datapath.sv
hw/rtl/dt_ctrl.sv
hw/rtl/decimal_truncate_top.sv
verif/tb_decimal_truncate_top.sv
